// ===== design/piqa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad input qualifier package
// Shared types, register indexes, reset values and axis compare helpers.
// ----------------------------------------------------------------------------
package piqa_pkg;

  localparam int unsigned BUTTON_W   = 16;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned PULL_W     = 8;
  localparam int unsigned STICK_TH_W = 15;
  localparam int unsigned TRIG_TH_W  = 8;
  localparam int unsigned REP_CFG_W  = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned HELD_OUT_W = 26;
  localparam int unsigned REP_OUT_W  = 24;
  localparam int unsigned FIRST_W    = 5;
  // Wide enough for channel numbers up to 63.
  localparam int unsigned CH_NUM_W   = 6;
  localparam int unsigned STICK_CH   = 8;
  localparam int unsigned TRIG_CH    = 2;

  localparam logic [STICK_TH_W-1:0] STICK_TH_RST  = 15'd16384;
  localparam logic [TRIG_TH_W-1:0]  TRIG_TH_RST   = 8'd127;
  localparam logic [REP_CFG_W-1:0]  REP_DELAY_RST = 16'd30;
  localparam logic [REP_CFG_W-1:0]  REP_IVL_RST   = 16'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STICK_TH  = 2'd0,
    CFG_TRIG_TH   = 2'd1,
    CFG_REP_DELAY = 2'd2,
    CFG_REP_IVL   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_e;

  // Axis at or above +threshold.
  function automatic logic axis_hi(logic signed [AXIS_W-1:0] a,
                                   logic [STICK_TH_W-1:0] t);
    return $signed({a[AXIS_W-1], a}) >= $signed({2'b00, t});
  endfunction

  // Axis at or below -threshold.
  function automatic logic axis_lo(logic signed [AXIS_W-1:0] a,
                                   logic [STICK_TH_W-1:0] t);
    return $signed({a[AXIS_W-1], a}) <= -$signed({2'b00, t});
  endfunction

endpackage

// ===== design/piqa_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad input qualifier input channel
// One sampled controller frame per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface piqa_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [piqa_pkg::BUTTON_W-1:0]   button_bits;
  logic signed [piqa_pkg::AXIS_W-1:0]     left_x;
  logic signed [piqa_pkg::AXIS_W-1:0]     left_y;
  logic signed [piqa_pkg::AXIS_W-1:0]     right_x;
  logic signed [piqa_pkg::AXIS_W-1:0]     right_y;
  logic        [piqa_pkg::PULL_W-1:0]     left_pull;
  logic        [piqa_pkg::PULL_W-1:0]     right_pull;

  modport source (output valid, button_bits, left_x, left_y, right_x, right_y,
                  left_pull, right_pull, input ready);
  modport sink   (input valid, button_bits, left_x, left_y, right_x, right_y,
                  left_pull, right_pull, output ready);
endinterface

// ===== design/piqa_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad input qualifier output channel
// One qualified result per frame, valid/ready handshake.
// ----------------------------------------------------------------------------
interface piqa_out_if;
  logic                                valid;
  logic                                ready;
  logic [piqa_pkg::HELD_OUT_W-1:0]     held_mask;
  logic [piqa_pkg::HELD_OUT_W-1:0]     press_mask;
  logic [piqa_pkg::HELD_OUT_W-1:0]     release_mask;
  logic [piqa_pkg::REP_OUT_W-1:0]      repeat_mask;
  logic [piqa_pkg::FIRST_W-1:0]        first_active;
  logic                                any_active;

  modport source (output valid, held_mask, press_mask, release_mask, repeat_mask,
                  first_active, any_active, input ready);
  modport sink   (input valid, held_mask, press_mask, release_mask, repeat_mask,
                  first_active, any_active, output ready);
endinterface

// ===== design/piqa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad input qualifier RAM
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
module piqa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pad_input_qualifier_autorepeat_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad input qualifier with auto-repeat
// Turns gamepad frames into held, press, release and typematic repeat masks.
// ----------------------------------------------------------------------------
// Each item is one controller frame. The block qualifies BUTTON_COUNT buttons,
// eight stick directions and two triggers, then walks the BUTTON_COUNT + 8
// hold counters one per cycle, when no division is running, through a single
// counter RAM. The repeat phase (count - delay) mod interval comes from one
// shared restoring divider that retires one bit per cycle. An item therefore
// occupies the block for one pass over the counters, plus one division for
// every channel whose hold count is above repeat_delay. The input is ready
// only between items; a finished result sits in an output register, so the
// next item can be taken while it waits. Hold counters need no clearing after
// reset: a counter is read as zero whenever its channel was not held on the
// previous frame.
module pad_input_qualifier_autorepeat_top #(
  parameter int unsigned BUTTON_COUNT = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  piqa_in_if.sink                             in_i,
  piqa_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [piqa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [piqa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned REP_CH  = BUTTON_COUNT + piqa_pkg::STICK_CH;
  localparam int unsigned ALL_CH  = REP_CH + piqa_pkg::TRIG_CH;
  localparam int unsigned HELD_W  = (ALL_CH > piqa_pkg::HELD_OUT_W) ?
                                    ALL_CH : piqa_pkg::HELD_OUT_W;
  localparam int unsigned REP_W   = (REP_CH > piqa_pkg::REP_OUT_W) ?
                                    REP_CH : piqa_pkg::REP_OUT_W;
  localparam int unsigned IDX_W   = $clog2(REP_CH);
  localparam int unsigned CMP_W   = (COUNT_WIDTH > piqa_pkg::REP_CFG_W) ?
                                    COUNT_WIDTH : piqa_pkg::REP_CFG_W;
  localparam int unsigned BIT_W   = $clog2(COUNT_WIDTH);
  localparam int unsigned LIVE_BT = (BUTTON_COUNT < piqa_pkg::BUTTON_W) ?
                                    BUTTON_COUNT : piqa_pkg::BUTTON_W;

  // Configuration registers.
  logic [piqa_pkg::STICK_TH_W-1:0] stick_th_q;
  logic [piqa_pkg::TRIG_TH_W-1:0]  trig_th_q;
  logic [piqa_pkg::REP_CFG_W-1:0]  delay_q;
  logic [piqa_pkg::REP_CFG_W-1:0]  ivl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_th_q <= piqa_pkg::STICK_TH_RST;
      trig_th_q  <= piqa_pkg::TRIG_TH_RST;
      delay_q    <= piqa_pkg::REP_DELAY_RST;
      ivl_q      <= piqa_pkg::REP_IVL_RST;
    end else if (cfg_we_i) begin
      unique case (piqa_pkg::cfg_idx_e'(cfg_idx_i))
        piqa_pkg::CFG_STICK_TH:  stick_th_q <= cfg_wdata_i[piqa_pkg::STICK_TH_W-1:0];
        piqa_pkg::CFG_TRIG_TH:   trig_th_q  <= cfg_wdata_i[piqa_pkg::TRIG_TH_W-1:0];
        piqa_pkg::CFG_REP_DELAY: delay_q    <= cfg_wdata_i;
        piqa_pkg::CFG_REP_IVL:   ivl_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame qualification, evaluated on the accepted item.
  logic [HELD_W-1:0]             held_in;
  logic [piqa_pkg::CH_NUM_W-1:0] first_in;

  always_comb begin
    held_in = '0;
    held_in[LIVE_BT-1:0] = in_i.button_bits[LIVE_BT-1:0];
    held_in[BUTTON_COUNT + 0] = piqa_pkg::axis_hi(in_i.left_y,  stick_th_q);
    held_in[BUTTON_COUNT + 1] = piqa_pkg::axis_lo(in_i.left_y,  stick_th_q);
    held_in[BUTTON_COUNT + 2] = piqa_pkg::axis_hi(in_i.left_x,  stick_th_q);
    held_in[BUTTON_COUNT + 3] = piqa_pkg::axis_lo(in_i.left_x,  stick_th_q);
    held_in[BUTTON_COUNT + 4] = piqa_pkg::axis_hi(in_i.right_y, stick_th_q);
    held_in[BUTTON_COUNT + 5] = piqa_pkg::axis_lo(in_i.right_y, stick_th_q);
    held_in[BUTTON_COUNT + 6] = piqa_pkg::axis_hi(in_i.right_x, stick_th_q);
    held_in[BUTTON_COUNT + 7] = piqa_pkg::axis_lo(in_i.right_x, stick_th_q);
    held_in[REP_CH]     = in_i.left_pull  > trig_th_q;
    held_in[REP_CH + 1] = in_i.right_pull > trig_th_q;
  end

  always_comb begin
    first_in = '0;
    for (int i = ALL_CH - 1; i >= 0; i--) begin
      if (held_in[i]) begin
        first_in = piqa_pkg::CH_NUM_W'(i);
      end
    end
  end

  // Sequencer and datapath registers.
  piqa_pkg::state_e              state_q, state_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [REP_W-1:0]              rep_q, rep_d;
  logic [piqa_pkg::REP_CFG_W-1:0] rem_q, rem_d;
  logic [COUNT_WIDTH-1:0]        dvd_q, dvd_d;
  logic [BIT_W-1:0]              bit_q, bit_d;
  logic [HELD_W-1:0]             held_q, prev_q;
  logic [piqa_pkg::CH_NUM_W-1:0] first_q;
  logic                          out_valid_q;

  logic                          in_acc;
  logic                          load_out;
  logic                          ch_done;
  logic                          ch_rep;
  logic                          ram_we;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [COUNT_WIDTH-1:0]        ram_rdata;
  logic [COUNT_WIDTH-1:0]        cnt_old;
  logic [COUNT_WIDTH-1:0]        cnt_new;
  logic [CMP_W-1:0]              cnt_ext;
  logic [CMP_W-1:0]              dly_ext;
  logic [CMP_W-1:0]              diff_ext;
  logic [piqa_pkg::REP_CFG_W-1:0] ivl_eff;
  logic [piqa_pkg::REP_CFG_W:0]  trial;
  logic [piqa_pkg::REP_CFG_W:0]  shifted;

  assign in_i.ready = (state_q == piqa_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ivl_eff    = (ivl_q == '0) ? piqa_pkg::REP_CFG_W'(1) : ivl_q;

  // The previous held bit doubles as the counter's valid bit.
  assign cnt_old  = prev_q[idx_q] ? ram_rdata : '0;
  assign cnt_new  = !held_q[idx_q] ? '0 :
                    (&cnt_old) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
  assign cnt_ext  = CMP_W'(cnt_new);
  assign dly_ext  = CMP_W'(delay_q);
  assign diff_ext = cnt_ext - dly_ext;

  // Restoring divider step: one remainder bit per cycle.
  assign shifted = {rem_q, dvd_q[COUNT_WIDTH-1]};
  assign trial   = shifted - {1'b0, ivl_eff};

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rep_d     = rep_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    bit_d     = bit_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    load_out  = 1'b0;
    ch_done   = 1'b0;
    ch_rep    = 1'b0;

    unique case (state_q)
      piqa_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_d   = '0;
          rep_d   = '0;
          state_d = piqa_pkg::ST_READ;
        end
      end
      piqa_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = piqa_pkg::ST_CALC;
      end
      piqa_pkg::ST_CALC: begin
        ram_we = 1'b1;
        if (cnt_ext > dly_ext) begin
          rem_d   = '0;
          dvd_d   = diff_ext[COUNT_WIDTH-1:0];
          bit_d   = BIT_W'(COUNT_WIDTH - 1);
          state_d = piqa_pkg::ST_DIV;
        end else begin
          ch_done = 1'b1;
          ch_rep  = (cnt_new == COUNT_WIDTH'(1));
        end
      end
      piqa_pkg::ST_DIV: begin
        rem_d = trial[piqa_pkg::REP_CFG_W] ? shifted[piqa_pkg::REP_CFG_W-1:0]
                                           : trial[piqa_pkg::REP_CFG_W-1:0];
        dvd_d = dvd_q << 1;
        bit_d = bit_q - BIT_W'(1);
        if (bit_q == '0) begin
          ch_done = 1'b1;
          ch_rep  = (rem_d == '0);
        end
      end
      piqa_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = piqa_pkg::ST_IDLE;
        end
      end
      default: state_d = piqa_pkg::ST_IDLE;
    endcase

    // Finish a channel and prefetch the next counter.
    if (ch_done) begin
      rep_d[idx_q] = ch_rep;
      if (idx_q == IDX_W'(REP_CH - 1)) begin
        state_d = piqa_pkg::ST_DONE;
      end else begin
        idx_d     = idx_q + IDX_W'(1);
        ram_re    = 1'b1;
        ram_raddr = idx_q + IDX_W'(1);
        state_d   = piqa_pkg::ST_CALC;
      end
    end
  end

  piqa_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (REP_CH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (cnt_new),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= piqa_pkg::ST_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        prev_q      <= held_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rep_q <= rep_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    bit_q <= bit_d;
    if (in_acc) begin
      held_q  <= held_in;
      first_q <= first_in;
    end
  end

  // Output register.
  logic [HELD_W-1:0] press_w;
  logic [HELD_W-1:0] release_w;

  assign press_w   = held_q & ~prev_q;
  assign release_w = prev_q & ~held_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.held_mask    <= held_q[piqa_pkg::HELD_OUT_W-1:0];
      out_o.press_mask   <= press_w[piqa_pkg::HELD_OUT_W-1:0];
      out_o.release_mask <= release_w[piqa_pkg::HELD_OUT_W-1:0];
      out_o.repeat_mask  <= rep_q[piqa_pkg::REP_OUT_W-1:0];
      out_o.first_active <= first_q[piqa_pkg::FIRST_W-1:0];
      out_o.any_active   <= |held_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // Checks.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == piqa_pkg::ST_READ)
    else $error("accepted item did not start the counter walk");

  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_o.press_mask & out_o.release_mask) == '0)
    else $error("press and release set on the same channel");

  a_press_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_o.press_mask & ~out_o.held_mask) == '0)
    else $error("press reported on a channel that is not held");

  a_any_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.held_mask != '0) |-> out_o.any_active)
    else $error("held channel without any_active");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == piqa_pkg::ST_IDLE)
    else $error("result load did not present the item");

endmodule
